// ===== design/spsc_pkg.sv =====
package spsc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int VAL_W       = 12;
    localparam int CAP_W       = 11;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CAP_W-1:0]  t_cap;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_val  wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic valid;
        logic accepted;
    } t_result;

endpackage

// ===== design/spsc_ram.sv =====
module spsc_ram (
    input  logic               i_clk,
    input  spsc_pkg::t_ram_req i_req,
    output spsc_pkg::t_val     o_rdata
);
    import spsc_pkg::*;

    t_val r_mem [STACK_DEPTH];
    t_val r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/spsc_ctrl.sv =====
module spsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spsc_pkg::t_val     i_pop_value,
    input  logic               i_last_item,
    input  spsc_pkg::t_size    i_cap,
    input  logic               i_out_free,
    output spsc_pkg::t_result  o_result,
    output spsc_pkg::t_ram_req o_ram_req,
    input  spsc_pkg::t_val     i_ram_rdata
);
    import spsc_pkg::*;

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_RUN    = 5'b00100,
        ST_LOAD   = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_val   r_top, n_top;
    t_size  r_size, n_size;
    t_val   r_next, n_next;
    logic   r_failed, n_failed;
    t_val   r_val, n_val;
    logic   r_last, n_last;

    t_state   done_state;
    t_val     push_val;
    t_size    below_top;
    logic     top_lt;
    logic     top_eq;

    assign push_val   = r_next + t_val'(1);
    assign below_top  = r_size - t_size'(2);
    assign top_lt     = r_top < r_val;
    assign top_eq     = r_top == r_val;
    assign done_state = r_last ? ST_RESULT : ST_IDLE;
    assign o_in_stall = r_state != ST_IDLE;

    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_size    = r_size;
        n_next    = r_next;
        n_failed  = r_failed;
        n_val     = r_val;
        n_last    = r_last;
        o_ram_req = '0;
        o_result  = '0;
        unique case (r_state)
            ST_INIT: begin
                // reseed the bottom entry with the value 1
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = '0;
                o_ram_req.wdata = t_val'(1);
                n_top    = t_val'(1);
                n_size   = t_size'(1);
                n_next   = t_val'(1);
                n_failed = 1'b0;
                n_state  = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_val  = i_pop_value;
                    n_last = i_last_item;
                    if (r_failed || (i_pop_value < r_top)) begin
                        n_failed = 1'b1;
                        n_state  = i_last_item ? ST_RESULT : ST_IDLE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (top_lt) begin
                    if (r_size >= i_cap) begin
                        n_failed = 1'b1;
                        n_state  = done_state;
                    end else begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = r_size[ADDR_W-1:0];
                        o_ram_req.wdata = push_val;
                        n_top  = push_val;
                        n_size = r_size + t_size'(1);
                        n_next = push_val;
                    end
                end else if (r_size > i_cap) begin
                    n_failed = 1'b1;
                    n_state  = done_state;
                end else if (top_eq) begin
                    if (r_size == t_size'(1)) begin
                        // stack runs empty: push the next number at the bottom
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = '0;
                        o_ram_req.wdata = push_val;
                        n_top   = push_val;
                        n_next  = push_val;
                        n_state = done_state;
                    end else begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = below_top[ADDR_W-1:0];
                        n_size  = r_size - t_size'(1);
                        n_state = ST_LOAD;
                    end
                end else begin
                    n_state = done_state;
                end
            end
            ST_LOAD: begin
                n_top   = i_ram_rdata;
                n_state = done_state;
            end
            ST_RESULT: begin
                if (i_out_free) begin
                    o_result.valid    = 1'b1;
                    o_result.accepted = !r_failed;
                    n_state           = ST_INIT;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_failed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_size <= n_size;
        r_next <= n_next;
        r_val  <= n_val;
        r_last <= n_last;
    end

endmodule

// ===== design/stack_pop_sequence_checker.sv =====
// Steps: an item is taken while idle and pushes numbers until the top reaches its value;
// a pop that leaves entries reloads the new top from the stack memory (one memory read port).
// Throughput: one item at a time; the input stalls until the item is done.
// After the last item of a sequence the block hands over the result, then reseeds.
// Reset: synchronous, active low; capacity returns to 1024 and the block writes the
// bottom stack entry before the first beat is taken.
module stack_pop_sequence_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  spsc_pkg::t_val i_pop_value,
    input  logic           i_last_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_accepted,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  spsc_pkg::t_cap i_cfg_data
);
    import spsc_pkg::*;

    t_cap     r_capacity;
    t_size    cap_eff;
    logic     r_out_valid;
    logic     r_accepted;
    logic     out_free;
    t_result  result;
    t_ram_req ram_req;
    t_val     ram_rdata;

    assign o_cfg_ready = 1'b1;
    // saturate the capacity at the stack depth
    assign cap_eff = (r_capacity > CAP_W'(STACK_DEPTH)) ? t_size'(STACK_DEPTH)
                                                        : t_size'(r_capacity);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(1024);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_accepted <= result.accepted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;

    spsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pop_value (i_pop_value),
        .i_last_item (i_last_item),
        .i_cap       (cap_eff),
        .i_out_free  (out_free),
        .o_result    (result),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    spsc_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== tb/tb.sv =====
module tb;

    import spsc_pkg::*;

    typedef struct {
        t_val value;
        logic last;
    } t_pop_beat;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {SEQ_WELL_FORMED, SEQ_BROKEN, SEQ_NOISE} t_seq_kind;

    localparam int MAX_POP_VALUE = 4095;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_val pop_value = '0;
    logic last_item = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic accepted;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    t_cap cfg_data  = '0;

    t_pop_beat pops_pending[$];
    bit        verdict_due[$];
    int        pop_order[$];
    int        items_queued  = 0;
    int        errors        = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    logic      in_taken      = 1'b0;

    // Predicted stack state
    t_val        stack_mem [STACK_DEPTH];
    int unsigned depth_used;
    int unsigned last_pushed;
    bit          seq_failed;
    t_cap        cap_reg = t_cap'(1024);

    stack_pop_sequence_checker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_pop_value (pop_value),
        .i_last_item (last_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_accepted  (accepted),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void reseed_stack();
        stack_mem[0] = t_val'(1);
        depth_used   = 1;
        last_pushed  = 1;
        seq_failed   = 1'b0;
    endfunction

    function automatic int unsigned stack_top();
        if (depth_used == 0 || depth_used - 1 >= STACK_DEPTH) begin
            return 0;
        end
        return stack_mem[depth_used - 1];
    endfunction

    function automatic void push_number();
        last_pushed++;
        if (depth_used < STACK_DEPTH) begin
            stack_mem[depth_used] = t_val'(last_pushed);
        end
        depth_used++;
    endfunction

    function automatic void check_pop(input t_val v);
        int unsigned limit;
        limit = (cap_reg > STACK_DEPTH) ? STACK_DEPTH : cap_reg;
        if (v > MAX_POP_VALUE || v < stack_top()) begin
            seq_failed = 1'b1;
            return;
        end
        while (stack_top() < v) begin
            if (depth_used >= limit) begin
                seq_failed = 1'b1;
                return;
            end
            push_number();
        end
        if (depth_used > limit) begin
            seq_failed = 1'b1;
            return;
        end
        if (stack_top() == v) begin
            depth_used--;
            // an emptied stack takes the next number straight away
            if (depth_used == 0) begin
                push_number();
            end
        end
    endfunction

    initial begin
        reseed_stack();
    end

    // Driver: hold a stalled beat, otherwise offer the next one or idle
    always @(negedge clk) begin : drive_beats
        t_pop_beat beat;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                beat = pops_pending.pop_front();
                in_valid  <= 1'b1;
                pop_value <= beat.value;
                last_item <= beat.last;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: check results first, then predict from the accepted input beat
    always @(posedge clk) begin : watch_beats
        bit due;
        if (rst_n) begin
            if (out_valid === 1'b1 && !out_stall) begin
                if (verdict_due.size() == 0) begin
                    report_mismatch($sformatf("result accepted=%b with none due", accepted));
                end else begin
                    due = verdict_due.pop_front();
                    if (accepted !== due) begin
                        report_mismatch($sformatf("accepted=%b, due %b", accepted, due));
                    end
                end
            end
            if (in_valid && in_stall === 1'b0) begin
                if (!seq_failed) begin
                    check_pop(pop_value);
                end
                if (last_item) begin
                    verdict_due.push_back(!seq_failed);
                    reseed_stack();
                end
            end
        end
        in_taken <= rst_n && in_valid && in_stall === 1'b0;
    end

    task automatic queue_pop(input int value, input bit last);
        t_pop_beat beat;
        beat.value = t_val'(value);
        beat.last  = last;
        pops_pending.push_back(beat);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (pops_pending.size() != 0 || in_valid || verdict_due.size() != 0) begin
            @(posedge clk);
        end
        // let the block hand over and reseed
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input t_cap value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cap_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 66;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 66;
            end
            default: begin
                send_idle_pct = 29;
                stall_pct     = 29;
            end
        endcase
    endtask

    // Random stack walk over 1..n gives a possible pop order
    task automatic build_pop_order(input int n);
        int held[$];
        int nxt;
        pop_order.delete();
        nxt = 1;
        while (pop_order.size() < n) begin
            if (held.size() == 0 || (nxt <= n && $urandom_range(1) == 1)) begin
                held.push_back(nxt);
                nxt++;
            end else begin
                pop_order.push_back(held.pop_back());
            end
        end
    endtask

    task automatic queue_sequence(input t_seq_kind kind);
        int n;
        int i;
        int r;
        int tmp;
        bit last;
        case (kind)
            SEQ_WELL_FORMED: begin
                n = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                build_pop_order(n);
            end
            SEQ_BROKEN: begin
                n = $urandom_range(2, 12);
                build_pop_order(n);
                i = $urandom_range(n - 2);
                if ($urandom_range(1) == 1) begin
                    tmp              = pop_order[i];
                    pop_order[i]     = pop_order[i + 1];
                    pop_order[i + 1] = tmp;
                end else begin
                    pop_order[i] = $urandom_range(n + 3);
                end
            end
            default: begin
                n = $urandom_range(1, 12);
                pop_order.delete();
                for (i = 0; i < n; i++) begin
                    r = $urandom_range(99);
                    if (r < 2) begin
                        pop_order.push_back($urandom_range(MAX_POP_VALUE));
                    end else if (r < 10) begin
                        pop_order.push_back($urandom_range(300));
                    end else begin
                        pop_order.push_back($urandom_range(15));
                    end
                end
            end
        endcase
        for (i = 0; i < n; i++) begin
            last = (i == n - 1) || (kind == SEQ_NOISE && $urandom_range(4) == 0);
            queue_pop(pop_order[i], last);
        end
    endtask

    task automatic queue_random_sequence();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            queue_sequence(SEQ_WELL_FORMED);
        end else if (r < 85) begin
            queue_sequence(SEQ_BROKEN);
        end else begin
            queue_sequence(SEQ_NOISE);
        end
    endtask

    initial begin : stimulus
        t_cap caps [12];
        int   p;
        int   start;
        caps = '{t_cap'(4), t_cap'(2), t_cap'(1024), t_cap'(3), t_cap'(2047), t_cap'(1),
                 t_cap'(6), t_cap'($urandom_range(1, 16)), t_cap'(1500),
                 t_cap'($urandom_range(2047)), t_cap'(10), t_cap'(1024)};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity
        set_idling(IDLE_NONE);
        queue_pop(1, 1);
        queue_pop(0, 1);
        queue_pop(4095, 1);
        queue_pop(3, 0); queue_pop(2, 0); queue_pop(1, 1);
        queue_pop(3, 0); queue_pop(1, 0); queue_pop(2, 1);
        // value already popped: one push, no pop
        queue_pop(2, 0); queue_pop(2, 0); queue_pop(3, 0); queue_pop(1, 1);
        // beats after a failure are dropped
        queue_pop(0, 0); queue_pop(5, 0); queue_pop(1, 1);
        wait_idle();

        write_capacity(t_cap'(0));
        queue_pop(1, 1);
        wait_idle();

        write_capacity(t_cap'(1));
        queue_pop(1, 0); queue_pop(2, 1);
        queue_pop(2, 1);
        wait_idle();

        // capacity above the stack depth saturates
        write_capacity(t_cap'(2047));
        queue_pop(1024, 1);
        queue_pop(1025, 1);
        wait_idle();

        for (p = 0; p < 12; p++) begin
            write_capacity(caps[p]);
            set_idling(t_idle_mode'(p % 4));
            start = items_queued;
            while (items_queued - start < 160) begin
                queue_random_sequence();
                // sender holds off until every verdict is back
                if (p == 5 && items_queued - start >= 80 && items_queued - start < 93) begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        repeat (16) @(posedge clk);
        if (verdict_due.size() != 0) begin
            report_mismatch($sformatf("%0d results still due", verdict_due.size()));
        end
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #24000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
